>>> rtl/crxd_pkg.sv
`default_nettype none

package crxd_pkg;

	localparam int ID_W   = 29;
	localparam int TIME_W = 32;
	localparam int CMD_W  = 2;
	localparam int KIND_W = 3;
	localparam int SLOT_W = 3;
	localparam int MAXRES = 8;
	localparam int NRES_W = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SUBSCRIBE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FRAME     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_SUBSCRIBED = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DUPLICATE  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELIVERED  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT    = 3'd4;

	// one slot of the subscription table
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] tmo;
		logic [TIME_W-1:0] last_rx;
	} crxd_entry_t;

	localparam int ENTRY_W = $bits(crxd_entry_t);

	// commands from controller to datapath
	typedef struct packed {
		logic ready;
		logic load;
		logic scan_run;
		logic do_subscribe;
		logic do_full;
		logic do_dup;
		logic do_deliver;
		logic do_unhandled;
		logic do_hit;
		logic do_flush;
	} crxd_ctrl_t;

	// status from datapath to controller
	typedef struct packed {
		logic             req_valid;
		logic [CMD_W-1:0] req_cmd;
		logic [CMD_W-1:0] cmd;
		logic             match;
		logic             due;
		logic             done;
		logic             free_found;
		logic             pend_v;
		logic             out_free;
	} crxd_stat_t;

endpackage

`default_nettype wire

>>> rtl/crxd_if.sv
`default_nettype none

// input item channel
interface crxd_req_if
	import crxd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ID_W-1:0]   frame_id;
	logic [TIME_W-1:0] supervision_ms;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, cmd, frame_id, supervision_ms, now_ms, input ready);
	modport sink (input valid, cmd, frame_id, supervision_ms, now_ms, output ready);
endinterface

// result item channel
interface crxd_res_if
	import crxd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SLOT_W-1:0] slot;
	logic [ID_W-1:0]   result_id;
	logic [TIME_W-1:0] unhandled_count;
	logic [TIME_W-1:0] timeout_count;
	logic              last;

	modport source (output valid, kind, slot, result_id, unhandled_count, timeout_count, last,
		input ready);
	modport sink (input valid, kind, slot, result_id, unhandled_count, timeout_count, last,
		output ready);
endinterface

`default_nettype wire

>>> rtl/crxd_ram.sv
`default_nettype none

module crxd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/crxd_datapath.sv
`default_nettype none

module crxd_datapath
	import crxd_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	crxd_req_if.sink          req,
	crxd_res_if.source        res,
	input  crxd_ctrl_t        ctrl,
	output crxd_stat_t        stat
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// latched item
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] tmo_q;
	logic [TIME_W-1:0] now_q;

	// walk state
	logic [CW-1:0]     addr_q;
	logic              rd_v_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic [IW-1:0]     free_q;
	logic              free_found_q;
	logic [NRES_W-1:0] nres_q;

	// per-slot flags and totals
	logic [SLOTS-1:0]  valid_q;
	logic [SLOTS-1:0]  expired_q;
	logic [TIME_W-1:0] unh_q;
	logic [TIME_W-1:0] tot_q;

	// timeout held back until its last flag is known
	logic              pend_v_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [TIME_W-1:0] pend_tcnt_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [ID_W-1:0]   out_id_q;
	logic [TIME_W-1:0] out_unh_q;
	logic [TIME_W-1:0] out_tcnt_q;
	logic              out_last_q;

	logic              accept;
	logic              issue;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	crxd_entry_t       ram_wdata;
	crxd_entry_t       rd_data;
	logic              cur_valid;
	logic              cur_exp;
	logic [TIME_W-1:0] deadline;
	logic [TIME_W-1:0] diff;
	logic              hit;
	logic              out_free;
	logic              out_load;
	logic              pend_push;
	logic [TIME_W-1:0] tot_inc;

	assign accept   = req.valid && ctrl.ready;
	assign req.ready = ctrl.ready;
	assign issue    = ctrl.scan_run && (addr_q != CW'(SLOTS));
	assign out_free = !out_valid_q || res.ready;
	assign tot_inc  = tot_q + 32'd1;

	// slot table storage
	always_comb begin
		ram_we    = ctrl.do_subscribe || ctrl.do_deliver;
		ram_waddr = ctrl.do_subscribe ? free_q : rd_idx_s1;
		if (ctrl.do_subscribe) begin
			ram_wdata = '{id: id_q, tmo: tmo_q, last_rx: '0};
		end else begin
			ram_wdata = '{id: rd_data.id, tmo: rd_data.tmo, last_rx: now_q};
		end
	end

	crxd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (addr_q[IW-1:0]),
		.rdata (rd_data)
	);

	// evaluation of the most recently read slot
	assign cur_valid = valid_q[rd_idx_s1];
	assign cur_exp   = expired_q[rd_idx_s1];
	assign deadline  = rd_data.last_rx + rd_data.tmo;
	assign diff      = now_q - deadline;
	assign hit       = !diff[TIME_W-1];

	always_comb begin
		stat            = '0;
		stat.req_valid  = req.valid;
		stat.req_cmd    = req.cmd;
		stat.cmd        = cmd_q;
		stat.match      = rd_v_s1 && cur_valid && (rd_data.id == id_q);
		stat.due        = rd_v_s1 && cur_valid && (rd_data.tmo != '0) && !cur_exp && hit
			&& (nres_q < NRES_W'(MAXRES));
		stat.done       = (addr_q == CW'(SLOTS)) && !rd_v_s1;
		stat.free_found = free_found_q;
		stat.pend_v     = pend_v_q;
		stat.out_free   = out_free;
	end

	assign pend_push = (ctrl.do_hit && pend_v_q) || ctrl.do_flush;
	assign out_load  = ctrl.do_subscribe || ctrl.do_full || ctrl.do_dup || ctrl.do_deliver
		|| pend_push;

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			id_q  <= req.frame_id;
			tmo_q <= req.supervision_ms;
			now_q <= req.now_ms;
		end
	end

	// walk control, slot flags and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			rd_v_s1      <= 1'b0;
			rd_idx_s1    <= '0;
			free_q       <= '0;
			free_found_q <= 1'b0;
			nres_q       <= '0;
			valid_q      <= '0;
			expired_q    <= '0;
			unh_q        <= '0;
			tot_q        <= '0;
			pend_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctrl.load) begin
				addr_q       <= '0;
				rd_v_s1      <= 1'b0;
				free_found_q <= 1'b0;
				nres_q       <= '0;
			end else if (ctrl.scan_run) begin
				if (issue) begin
					addr_q <= addr_q + CW'(1);
				end
				rd_v_s1   <= issue;
				rd_idx_s1 <= addr_q[IW-1:0];
				if (rd_v_s1 && !cur_valid && !free_found_q) begin
					free_q       <= rd_idx_s1;
					free_found_q <= 1'b1;
				end
			end
			if (ctrl.do_subscribe) begin
				valid_q[free_q]   <= 1'b1;
				expired_q[free_q] <= 1'b0;
			end
			if (ctrl.do_deliver) begin
				expired_q[rd_idx_s1] <= 1'b0;
			end
			if (ctrl.do_unhandled) begin
				unh_q <= unh_q + 32'd1;
			end
			if (ctrl.do_hit) begin
				expired_q[rd_idx_s1] <= 1'b1;
				tot_q                <= tot_inc;
				nres_q               <= nres_q + NRES_W'(1);
				pend_v_q             <= 1'b1;
			end else if (ctrl.do_flush) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending timeout and result payload
	always_ff @(posedge clk) begin
		if (ctrl.do_hit) begin
			pend_slot_q <= SLOT_W'(rd_idx_s1);
			pend_id_q   <= rd_data.id;
			pend_tcnt_q <= tot_inc;
		end
		if (out_load) begin
			out_unh_q  <= unh_q;
			out_tcnt_q <= tot_q;
			out_id_q   <= id_q;
			out_last_q <= 1'b1;
			if (ctrl.do_subscribe) begin
				out_kind_q <= KIND_SUBSCRIBED;
				out_slot_q <= SLOT_W'(free_q);
			end else if (ctrl.do_full) begin
				out_kind_q <= KIND_FULL;
				out_slot_q <= '0;
			end else if (ctrl.do_dup) begin
				out_kind_q <= KIND_DUPLICATE;
				out_slot_q <= SLOT_W'(rd_idx_s1);
			end else if (ctrl.do_deliver) begin
				out_kind_q <= KIND_DELIVERED;
				out_slot_q <= SLOT_W'(rd_idx_s1);
			end else begin
				out_kind_q <= KIND_TIMEOUT;
				out_slot_q <= pend_slot_q;
				out_id_q   <= pend_id_q;
				out_tcnt_q <= pend_tcnt_q;
				out_last_q <= ctrl.do_flush;
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.kind            = out_kind_q;
	assign res.slot            = out_slot_q;
	assign res.result_id       = out_id_q;
	assign res.unhandled_count = out_unh_q;
	assign res.timeout_count   = out_tcnt_q;
	assign res.last            = out_last_q;

`ifndef SYNTHESIS
	// a slot is only ever marked timed out once subscribed
	a_expired_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(expired_q & ~valid_q) == '0)
		else $error("timed-out flag on an unsubscribed slot");

	// no more timeouts per tick than the result limit
	a_nres_limit: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= NRES_W'(MAXRES))
		else $error("timeout results exceed limit");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_valid_q) |-> res.ready)
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

>>> rtl/crxd_ctrl.sv
`default_nettype none

module crxd_ctrl
	import crxd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  crxd_stat_t stat,
	output crxd_ctrl_t ctrl
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and datapath commands
	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.ready = 1'b1;
				if (stat.req_valid) begin
					ctrl.load = 1'b1;
					if (stat.req_cmd == CMD_SUBSCRIBE || stat.req_cmd == CMD_FRAME
						|| stat.req_cmd == CMD_TICK) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (stat.cmd == CMD_SUBSCRIBE) begin
					if (stat.match) begin
						if (stat.out_free) begin
							ctrl.do_dup = 1'b1;
							state_d     = ST_IDLE;
						end
					end else if (stat.done) begin
						if (stat.out_free) begin
							ctrl.do_subscribe = stat.free_found;
							ctrl.do_full      = !stat.free_found;
							state_d           = ST_IDLE;
						end
					end else begin
						ctrl.scan_run = 1'b1;
					end
				end else if (stat.cmd == CMD_FRAME) begin
					if (stat.match) begin
						if (stat.out_free) begin
							ctrl.do_deliver = 1'b1;
							state_d         = ST_IDLE;
						end
					end else if (stat.done) begin
						ctrl.do_unhandled = 1'b1;
						state_d           = ST_IDLE;
					end else begin
						ctrl.scan_run = 1'b1;
					end
				end else if (stat.cmd == CMD_TICK) begin
					if (stat.due) begin
						if (!stat.pend_v || stat.out_free) begin
							ctrl.do_hit   = 1'b1;
							ctrl.scan_run = 1'b1;
						end
					end else if (stat.done) begin
						if (!stat.pend_v) begin
							state_d = ST_IDLE;
						end else if (stat.out_free) begin
							ctrl.do_flush = 1'b1;
							state_d       = ST_IDLE;
						end
					end else begin
						ctrl.scan_run = 1'b1;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// the last timeout is always flushed before a new item is taken
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !stat.pend_v)
		else $error("pending timeout left behind");

	// a new timeout only displaces a pending one when the output can take it
	a_hit_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.do_hit |-> (!stat.pend_v || stat.out_free))
		else $error("pending timeout lost");

	// a subscribe only claims a slot that the walk found free
	a_sub_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.do_subscribe |-> (stat.free_found && stat.done))
		else $error("subscribe without a free slot");
`endif

endmodule

`default_nettype wire

>>> rtl/can_rx_id_dispatch_timeout.sv
// channel  modport  direction  payload
// req      sink     in         cmd, frame_id, supervision_ms, now_ms
// res      source   out        kind, slot, result_id, unhandled_count, timeout_count, last
//
// each item walks the slot table through one read port, one slot per cycle
// unless the walk is held; a subscribe or frame match ends the walk early,
// and the next item is taken only after the walk has ended.
// an unknown command is taken and gives no result.
// reset clears the valid and timed-out flags and the totals; no clearing pass.
// a full result register with ready low holds the walk until it is taken.
`default_nettype none

module can_rx_id_dispatch_timeout
	import crxd_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	crxd_req_if.sink   req,
	crxd_res_if.source res
);

	crxd_ctrl_t ctrl;
	crxd_stat_t stat;

	// sequencer
	crxd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// slot table, counters and result register
	crxd_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.ctrl   (ctrl),
		.stat   (stat)
	);

endmodule

`default_nettype wire

>>> verif/tb_can_rx_id_dispatch_timeout.sv
`default_nettype none

module tb_can_rx_id_dispatch_timeout
	import crxd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 8;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int RANDOM_ITEMS = 128;
	localparam int LONG_HOLD = 300;
	localparam int MAX_REPORTS = 10;

	// one expected or observed result item
	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] unhandled;
		logic [TIME_W-1:0] timeouts;
		logic              last;
	} result_t;

	// subscription table mirror, deadline check and expected result store
	class subscription_tracker;
		bit                slot_used[SLOTS];
		logic [ID_W-1:0]   slot_id[SLOTS];
		logic [TIME_W-1:0] slot_tmo[SLOTS];
		logic [TIME_W-1:0] slot_seen[SLOTS];
		bit                slot_late[SLOTS];
		logic [TIME_W-1:0] unhandled_total;
		logic [TIME_W-1:0] timeout_total;
		result_t           pending_results[$];
		int                mismatch_total;

		function new();
			for (int k = 0; k < SLOTS; k++) begin
				slot_used[k] = 1'b0;
				slot_late[k] = 1'b0;
				slot_id[k] = '0;
			end
			unhandled_total = '0;
			timeout_total = '0;
			mismatch_total = 0;
		endfunction

		function void push(logic [KIND_W-1:0] kind, int k, logic [ID_W-1:0] id);
			result_t r;
			r.kind = kind;
			r.slot = k[SLOT_W-1:0];
			r.id = id;
			r.unhandled = unhandled_total;
			r.timeouts = timeout_total;
			r.last = 1'b0;
			pending_results.push_back(r);
		endfunction

		// work out the results of one accepted request
		function void accept_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
				logic [TIME_W-1:0] tmo, logic [TIME_W-1:0] now);
			int base;
			int hit;
			int n;
			logic [TIME_W-1:0] diff;
			base = pending_results.size();
			hit = -1;
			n = 0;
			for (int k = SLOTS - 1; k >= 0; k--)
				if (slot_used[k] && slot_id[k] == id) hit = k;
			case (cmd)
				CMD_SUBSCRIBE: begin
					if (hit >= 0) begin
						push(KIND_DUPLICATE, hit, id);
					end else begin
						for (int k = SLOTS - 1; k >= 0; k--)
							if (!slot_used[k]) hit = k;
						if (hit >= 0) begin
							slot_used[hit] = 1'b1;
							slot_id[hit] = id;
							slot_tmo[hit] = tmo;
							slot_seen[hit] = '0;
							slot_late[hit] = 1'b0;
							push(KIND_SUBSCRIBED, hit, id);
						end else begin
							push(KIND_FULL, 0, id);
						end
					end
				end
				CMD_FRAME: begin
					if (hit >= 0) begin
						slot_seen[hit] = now;
						slot_late[hit] = 1'b0;
						push(KIND_DELIVERED, hit, id);
					end else begin
						unhandled_total = unhandled_total + 1'b1;
					end
				end
				CMD_TICK: begin
					// wrap-safe deadline: signed difference not negative
					for (int k = 0; k < SLOTS && n < MAXRES; k++) begin
						if (!slot_used[k] || slot_tmo[k] == '0 || slot_late[k]) continue;
						diff = now - (slot_seen[k] + slot_tmo[k]);
						if (!diff[TIME_W-1]) begin
							slot_late[k] = 1'b1;
							timeout_total = timeout_total + 1'b1;
							push(KIND_TIMEOUT, k, slot_id[k]);
							n++;
						end
					end
				end
				default: ;
			endcase
			if (pending_results.size() > base)
				pending_results[pending_results.size() - 1].last = 1'b1;
		endfunction

		// compare one result item with the oldest expectation
		function void compare_result(result_t got);
			result_t exp_r;
			if (pending_results.size() == 0) begin
				mismatch_total++;
				if (mismatch_total <= MAX_REPORTS)
					$display("unexpected result: kind %0d slot %0d id %h",
						got.kind, got.slot, got.id);
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.kind !== exp_r.kind || got.slot !== exp_r.slot || got.id !== exp_r.id ||
					got.unhandled !== exp_r.unhandled || got.timeouts !== exp_r.timeouts ||
					got.last !== exp_r.last) begin
				mismatch_total++;
				if (mismatch_total <= MAX_REPORTS) begin
					$display("mismatch expected: kind %0d slot %0d id %h unh %h tmo %h last %b",
						exp_r.kind, exp_r.slot, exp_r.id, exp_r.unhandled, exp_r.timeouts,
						exp_r.last);
					$display("         actual:   kind %0d slot %0d id %h unh %h tmo %h last %b",
						got.kind, got.slot, got.id, got.unhandled, got.timeouts, got.last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet_phase;
	logic [TIME_W-1:0] clock_ms;

	subscription_tracker tracker = new();

	crxd_req_if req_ch ();
	crxd_res_if res_ch ();

	can_rx_id_dispatch_timeout #(.SLOTS(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// idle length: mostly short, now and then long
	function automatic int next_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// offer one request item and wait until it is taken
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] tmo, input logic [TIME_W-1:0] now);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.frame_id <= id;
		req_ch.supervision_ms <= tmo;
		req_ch.now_ms <= now;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		tracker.accept_request(cmd, id, tmo, now);
		gap = (!quiet_phase && $urandom_range(0, 2) == 0) ? next_gap() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// move the millisecond time on, with an occasional jump anywhere
	task automatic advance_clock();
		if ($urandom_range(0, 29) == 0) clock_ms = $urandom();
		else clock_ms = clock_ms + $urandom_range(0, 15);
	endtask

	// directed part: table fill, duplicate, full, wrap and sign edge of the deadline
	task automatic run_directed();
		send_item(CMD_SUBSCRIBE, 29'h0, 32'd5, 32'h0);
		send_item(CMD_SUBSCRIBE, 29'h1FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		send_item(CMD_SUBSCRIBE, 29'h0ABC_DEF1, 32'hFFFF_FFFF, 32'h0);
		send_item(CMD_SUBSCRIBE, 29'h0, 32'd77, 32'h0);
		send_item(CMD_TICK, 29'h0, 32'h0, 32'h0);
		send_item(CMD_FRAME, 29'h5, 32'h0, 32'h1234);
		send_item(CMD_SUBSCRIBE, 29'h100, 32'd3, 32'h0);
		send_item(CMD_SUBSCRIBE, 29'h200, 32'd10, 32'h0);
		send_item(CMD_SUBSCRIBE, 29'h300, 32'd20, 32'h0);
		send_item(CMD_SUBSCRIBE, 29'h400, 32'd40, 32'h0);
		send_item(CMD_SUBSCRIBE, 29'h500, 32'd1, 32'h0);
		send_item(CMD_SUBSCRIBE, 29'h600, 32'd9, 32'h0);
		send_item(CMD_UNKNOWN, 29'h1FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// every supervised slot due at once
		send_item(CMD_TICK, 29'h0, 32'h0, 32'd100);
		send_item(CMD_TICK, 29'h0, 32'h0, 32'd101);
		send_item(CMD_FRAME, 29'h0, 32'h0, 32'hFFFF_FFF0);
		send_item(CMD_FRAME, 29'h1FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		send_item(CMD_TICK, 29'h0, 32'h0, 32'hFFFF_FFF4);
		// deadline wrapped past zero
		send_item(CMD_TICK, 29'h0, 32'h0, 32'd2);
		// difference of exactly half the range counts as not reached
		send_item(CMD_FRAME, 29'h100, 32'h0, 32'h7FFF_FFFD);
		send_item(CMD_TICK, 29'h0, 32'h0, 32'h0);
		send_item(CMD_TICK, 29'h0, 32'h0, 32'hFFFF_FFFF);
	endtask

	// random part: mostly frames and ticks on subscribed identifiers
	task automatic run_random();
		int counted;
		int pick;
		logic [ID_W-1:0] id;
		counted = 0;
		clock_ms = 32'd200;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 40 == 0) quiet_phase = !quiet_phase;
			pick = $urandom_range(0, 99);
			id = ($urandom_range(0, 3) != 0) ? tracker.slot_id[$urandom_range(0, SLOTS - 1)]
				: ID_W'($urandom());
			if (pick < 5) begin
				send_item(CMD_UNKNOWN, ID_W'($urandom()), $urandom(), $urandom());
			end else if (pick < 20) begin
				send_item(CMD_SUBSCRIBE, id, $urandom(), $urandom());
			end else if (pick < 62) begin
				advance_clock();
				send_item(CMD_FRAME, id, $urandom(), clock_ms);
			end else begin
				advance_clock();
				send_item(CMD_TICK, ID_W'($urandom()), $urandom(), clock_ms);
			end
			counted++;
		end
	endtask

	// request side and end of run
	initial begin : stimulus
		arst_n = 1'b0;
		quiet_phase = 1'b1;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_SUBSCRIBE;
		req_ch.frame_id <= '0;
		req_ch.supervision_ms <= '0;
		req_ch.now_ms <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		req_ch.valid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (3 * SLOTS + 10) @(posedge clk);
		if (tracker.mismatch_total == 0 && tracker.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side: random back-pressure and one long hold
	initial begin : result_sink
		int gap;
		int taken;
		bit held;
		result_t got;
		gap = 0;
		taken = 0;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.kind = res_ch.kind;
				got.slot = res_ch.slot;
				got.id = res_ch.result_id;
				got.unhandled = res_ch.unhandled_count;
				got.timeouts = res_ch.timeout_count;
				got.last = res_ch.last;
				tracker.compare_result(got);
				taken++;
				if (taken == 30 && !held) begin
					gap = LONG_HOLD;
					held = 1'b1;
				end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
					gap = next_gap();
				end
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				gap--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin : watchdog
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
